// File: sv/rsld_pkg.sv
// ----------------------------------------------------------------------------
// rsld_pkg: shared types and constants of the run-length sprite line decoder
// Holds the phase encoding, the stream constants, the configuration bundle and
// the result record that travels from the front end through the queue.
// ----------------------------------------------------------------------------
package rsld_pkg;

  // Stream word constants.
  localparam logic [15:0] RunTag   = 16'hC000;
  localparam logic [15:0] RunCount = 16'h3FFF;
  localparam logic [7:0]  ChanMask = 8'hF8;

  // Configuration register indexes.
  localparam logic [1:0] RegRawMode      = 2'd0;
  localparam logic [1:0] RegGreenSixBits = 2'd1;
  localparam logic [1:0] RegLineWidth    = 2'd2;

  // Decoder phase within a run-length coded line.
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_CMD    = 2'd1,
    PH_RUN    = 2'd2
  } phase_e;

  // Configuration registers as one bundle.
  typedef struct packed {
    logic        raw_mode;
    logic        green_six_bits;
    logic [14:0] line_width;
  } cfg_t;

  // One classified result waiting to be expanded.
  typedef struct packed {
    logic [15:0] word;
    logic [14:0] x;
    logic        is_pixel;
    logic        line_end;
  } item_t;

endpackage

// File: sv/rle_sprite_line_decoder_unit.sv
// ----------------------------------------------------------------------------
// rle_sprite_line_decoder_unit: run-length sprite line decoder
// Decodes a stream of 16-bit sprite words into positioned 24-bit pixels and
// line-end markers, in run-length coded or raw mode.
//
//   Channel   Direction  Handshake              Payload
//   input     in         push / full            word_i
//   result    out        empty / pop            x_o, red_o, green_o, blue_o,
//                                               is_pixel_o, line_end_o
//   config    in         cfg_we_i (no wait)     cfg_idx_i, cfg_data_i
//
// One word is taken per cycle unless full; a result is queued as its word is
// accepted and reaches the result ports once older results are popped. The
// front state machine settles each word combinationally, and a result queue
// of QueueDepth entries decouples it from the consumer: full rises only when
// the queue holds QueueDepth results. Reset clears the line state, the queue
// and the registers to raw mode off, 565 packing and a line width of one.
// ----------------------------------------------------------------------------
module rle_sprite_line_decoder_unit #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel.
  input  logic        push,
  output logic        full,
  input  logic [15:0] word_i,
  // Result channel.
  output logic        empty,
  input  logic        pop,
  output logic [14:0] x_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        is_pixel_o,
  output logic        line_end_o,
  // Configuration port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i
);

  rsld_pkg::cfg_t  cfg_q;
  rsld_pkg::item_t front_item;
  rsld_pkg::item_t head_item;
  logic            front_valid;
  logic            in_accept;

  assign in_accept = push && !full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.raw_mode       <= 1'b0;
      cfg_q.green_six_bits <= 1'b1;
      cfg_q.line_width     <= 15'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rsld_pkg::RegRawMode:      cfg_q.raw_mode       <= cfg_data_i[0];
        rsld_pkg::RegGreenSixBits: cfg_q.green_six_bits <= cfg_data_i[0];
        rsld_pkg::RegLineWidth:    cfg_q.line_width     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front end: line state machine and classification.
  rsld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .word_i      (word_i),
    .cfg_i       (cfg_q),
    .res_valid_o (front_valid),
    .res_o       (front_item)
  );

  // Result queue.
  rsld_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_accept && front_valid),
    .wr_data_i (front_item),
    .rd_en_i   (pop),
    .rd_data_o (head_item),
    .full_o    (full),
    .empty_o   (empty)
  );

  // Back end: color expansion of the oldest result.
  rsld_back u_back (
    .item_i           (head_item),
    .green_six_bits_i (cfg_q.green_six_bits),
    .x_o              (x_o),
    .red_o            (red_o),
    .green_o          (green_o),
    .blue_o           (blue_o),
    .is_pixel_o       (is_pixel_o),
    .line_end_o       (line_end_o)
  );

  // Every word accepted in raw mode leaves a result behind.
  a_raw_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && cfg_q.raw_mode) |=> !empty)
    else $error("raw mode word produced no result");

  // A delivered pixel always lies inside the line.
  a_pixel_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_pixel_o) |-> ({1'b0, x_o} < {1'b0, cfg_q.line_width}))
    else $error("pixel column beyond line width");

  // A marker is a bare line end with no color.
  a_marker_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !is_pixel_o) |-> (line_end_o && x_o == '0 && red_o == '0 &&
                                  green_o == '0 && blue_o == '0))
    else $error("malformed line-end marker");

endmodule

// File: sv/rsld_front.sv
// ----------------------------------------------------------------------------
// rsld_front: word classifier and line state machine
// Takes one stream word per accepted transaction, updates phase, run count and
// column, and decides whether the word yields a pixel, a line-end marker or
// nothing.
// ----------------------------------------------------------------------------
module rsld_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [15:0]        word_i,
  input  rsld_pkg::cfg_t     cfg_i,
  output logic               res_valid_o,
  output rsld_pkg::item_t    res_o
);

  rsld_pkg::phase_e phase_q, phase_d;
  logic [13:0]      run_left_q, run_left_d;
  logic [15:0]      column_q, column_d;

  logic [16:0] col_plus_one;
  logic [16:0] col_plus_word;
  logic [15:0] col_inc;
  logic [15:0] col_skip;
  logic [13:0] run_dec;
  logic        col_shown;
  logic        col_ends;

  // Column arithmetic shared by all modes; the column saturates at its top.
  always_comb begin
    col_plus_one  = {1'b0, column_q} + 17'd1;
    col_plus_word = {1'b0, column_q} + {1'b0, word_i};
    col_inc       = col_plus_one[16] ? 16'hFFFF : col_plus_one[15:0];
    col_skip      = col_plus_word[16] ? 16'hFFFF : col_plus_word[15:0];
    col_shown     = column_q < {1'b0, cfg_i.line_width};
    col_ends      = col_plus_one >= {2'b00, cfg_i.line_width};
    run_dec       = run_left_q - 14'd1;
  end

  // Next state and the classified result.
  always_comb begin
    phase_d          = phase_q;
    run_left_d       = run_left_q;
    column_d         = column_q;
    res_valid_o      = 1'b0;
    res_o.word       = word_i;
    res_o.x          = column_q[14:0];
    res_o.is_pixel   = 1'b1;
    res_o.line_end   = 1'b0;

    if (cfg_i.raw_mode) begin
      res_valid_o = 1'b1;
      if (col_shown) begin
        res_o.line_end = col_ends;
      end else begin
        res_o.word     = '0;
        res_o.x        = '0;
        res_o.is_pixel = 1'b0;
        res_o.line_end = 1'b1;
      end
      if (col_ends) begin
        column_d   = '0;
        phase_d    = rsld_pkg::PH_HEADER;
        run_left_d = '0;
      end else begin
        column_d = col_inc;
      end
    end else begin
      case (phase_q)
        rsld_pkg::PH_HEADER: begin
          phase_d    = rsld_pkg::PH_CMD;
          column_d   = '0;
          run_left_d = '0;
        end
        rsld_pkg::PH_RUN: begin
          res_valid_o = col_shown;
          column_d    = col_inc;
          run_left_d  = run_dec;
          if (run_dec == '0) begin
            phase_d = rsld_pkg::PH_CMD;
          end
        end
        default: begin
          // Command word: line end, run opener or transparent skip.
          if (word_i == '0) begin
            res_valid_o    = 1'b1;
            res_o.word     = '0;
            res_o.x        = '0;
            res_o.is_pixel = 1'b0;
            res_o.line_end = 1'b1;
            phase_d        = rsld_pkg::PH_HEADER;
            column_d       = '0;
            run_left_d     = '0;
          end else if ((word_i & rsld_pkg::RunTag) == rsld_pkg::RunTag) begin
            run_left_d = word_i[13:0];
            phase_d    = (word_i[13:0] != '0) ? rsld_pkg::PH_RUN : rsld_pkg::PH_CMD;
          end else begin
            column_d = col_skip;
            phase_d  = rsld_pkg::PH_CMD;
          end
        end
      endcase
    end
  end

  // State registers advance only on an accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rsld_pkg::PH_HEADER;
      run_left_q <= '0;
      column_q   <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      run_left_q <= run_left_d;
      column_q   <= column_d;
    end
  end

endmodule

// File: sv/rsld_queue.sv
// ----------------------------------------------------------------------------
// rsld_queue: result queue between the front end and the back end
// A small register FIFO of classified results; it lets the front end keep
// taking words while the consumer stalls, until it fills.
// ----------------------------------------------------------------------------
module rsld_queue #(
  parameter int Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  rsld_pkg::item_t wr_data_i,
  input  logic            rd_en_i,
  output rsld_pkg::item_t rd_data_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rsld_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == FullCnt);
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// File: sv/rsld_back.sv
// ----------------------------------------------------------------------------
// rsld_back: pixel expansion
// Unpacks the oldest queued word from 555 or 565 packing into 8-bit channels
// with the low three bits clear, and zeroes the colors of line-end markers.
// ----------------------------------------------------------------------------
module rsld_back (
  input  rsld_pkg::item_t item_i,
  input  logic            green_six_bits_i,
  output logic [14:0]     x_o,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o,
  output logic            is_pixel_o,
  output logic            line_end_o
);

  logic [7:0] red_raw, green_raw, blue_raw;

  // Channel extraction for both packings.
  always_comb begin
    if (green_six_bits_i) begin
      red_raw   = {item_i.word[15:11], 3'b000};
      green_raw = {item_i.word[10:6], 3'b000};
    end else begin
      red_raw   = {item_i.word[14:10], 3'b000};
      green_raw = {item_i.word[9:5], 3'b000};
    end
    blue_raw = {item_i.word[4:0], 3'b000};
  end

  // Markers carry no color and no column.
  always_comb begin
    is_pixel_o = item_i.is_pixel;
    line_end_o = item_i.line_end;
    x_o        = item_i.is_pixel ? item_i.x : '0;
    red_o      = item_i.is_pixel ? (red_raw & rsld_pkg::ChanMask) : '0;
    green_o    = item_i.is_pixel ? (green_raw & rsld_pkg::ChanMask) : '0;
    blue_o     = item_i.is_pixel ? (blue_raw & rsld_pkg::ChanMask) : '0;
  end

endmodule

// File: sim/tb_rle_sprite_line_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_rle_sprite_line_decoder_unit: self-checking bench of the sprite line decoder
// Feeds run-length coded and raw sprite word streams through the push / full
// port and predicts every pixel and line-end marker in step with the stream.
// Each popped result is compared with the oldest prediction. Both ports idle
// and stall at random, and the registers are changed between streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rle_sprite_line_decoder_unit;

  localparam int LimitCycles = 600000;
  localparam int MaxReported = 10;

  // One decoded result as it leaves the block.
  typedef struct packed {
    logic [14:0] x;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        is_pixel;
    logic        line_end;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [15:0] word_i;
  logic        empty;
  logic        pop = 1'b0;
  logic [14:0] x_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic        is_pixel_o;
  logic        line_end_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [14:0] cfg_data_i;

  // Predicted decoder state and registers.
  rsld_pkg::cfg_t   cfg_q;
  rsld_pkg::phase_e line_phase;
  logic [13:0]      run_left_q;
  logic [15:0]      column_q;

  pixel_t      pixel_queue[$];
  int          failures = 0;
  int          cycles = 0;
  int          words_sent = 0;
  int          pixels_seen = 0;
  int          markers_seen = 0;
  int          settings_done = 0;
  int          burst_left = 0;
  logic [15:0] stall_bits = 16'hFFFF;
  logic [3:0]  stall_pos = '0;

  rle_sprite_line_decoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .word_i     (word_i),
    .empty      (empty),
    .pop        (pop),
    .x_o        (x_o),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o),
    .is_pixel_o (is_pixel_o),
    .line_end_o (line_end_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LimitCycles) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pixel_queue.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Column advance that sticks at the top of the 16-bit range.
  function automatic logic [15:0] column_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // Expands one packed pixel word to 8-bit channels at the given column.
  function automatic pixel_t expand_pixel(logic [15:0] w, logic [15:0] col, logic last);
    pixel_t p;
    p.x = col[14:0];
    if (cfg_q.green_six_bits) begin
      p.red   = {w[15:11], 3'b000};
      p.green = {w[10:6], 3'b000};
    end else begin
      p.red   = {w[14:10], 3'b000};
      p.green = {w[9:5], 3'b000};
    end
    p.blue     = {w[4:0], 3'b000};
    p.is_pixel = 1'b1;
    p.line_end = last;
    return p;
  endfunction

  // Advances the predicted state by one word; returns 1 when a result is due.
  function automatic bit decode_word(input logic [15:0] w, output pixel_t px);
    logic [16:0] col_next;
    logic [15:0] count;
    bit          shown;
    bit          ends;
    bit          has;
    px = '0;
    px.line_end = 1'b1;
    has = 1'b0;
    if (cfg_q.raw_mode) begin
      col_next = {1'b0, column_q} + 17'd1;
      shown = column_q < {1'b0, cfg_q.line_width};
      ends = col_next >= {2'b00, cfg_q.line_width};
      if (shown) px = expand_pixel(w, column_q, ends);
      if (ends) begin
        column_q = '0;
        run_left_q = '0;
        line_phase = rsld_pkg::PH_HEADER;
      end else begin
        column_q = column_add(column_q, 16'd1);
      end
      has = 1'b1;
    end else begin
      case (line_phase)
        rsld_pkg::PH_HEADER: begin
          line_phase = rsld_pkg::PH_CMD;
          column_q = '0;
          run_left_q = '0;
        end
        rsld_pkg::PH_RUN: begin
          shown = column_q < {1'b0, cfg_q.line_width};
          if (shown) px = expand_pixel(w, column_q, 1'b0);
          has = shown;
          column_q = column_add(column_q, 16'd1);
          run_left_q = run_left_q - 14'd1;
          if (run_left_q == '0) line_phase = rsld_pkg::PH_CMD;
        end
        default: begin
          if (w == 16'h0000) begin
            // End of line: marker only.
            has = 1'b1;
            line_phase = rsld_pkg::PH_HEADER;
            column_q = '0;
            run_left_q = '0;
          end else if ((w & rsld_pkg::RunTag) == rsld_pkg::RunTag) begin
            count = w & rsld_pkg::RunCount;
            run_left_q = count[13:0];
            line_phase = (count != 16'd0) ? rsld_pkg::PH_RUN : rsld_pkg::PH_CMD;
          end else begin
            // Transparent skip.
            column_q = column_add(column_q, w);
            line_phase = rsld_pkg::PH_CMD;
          end
        end
      endcase
    end
    return has;
  endfunction

  // Tracks register writes and accepted words, and checks every popped result.
  always @(posedge clk_i) begin
    pixel_t want;
    pixel_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rsld_pkg::RegRawMode:      cfg_q.raw_mode = cfg_data_i[0];
          rsld_pkg::RegGreenSixBits: cfg_q.green_six_bits = cfg_data_i[0];
          rsld_pkg::RegLineWidth:    cfg_q.line_width = cfg_data_i;
          default: ;
        endcase
      end
      if (push && !full) begin
        if (decode_word(word_i, want)) pixel_queue.push_back(want);
      end
      if (pop && !empty) begin
        got = '{x: x_o, red: red_o, green: green_o, blue: blue_o,
                is_pixel: is_pixel_o, line_end: line_end_o};
        if (got.is_pixel) pixels_seen++;
        else markers_seen++;
        if (pixel_queue.size() == 0) begin
          failures++;
          if (failures <= MaxReported)
            $display("unexpected result: x=%0d rgb=%02h%02h%02h pix=%0b end=%0b",
                     got.x, got.red, got.green, got.blue, got.is_pixel, got.line_end);
        end else begin
          want = pixel_queue.pop_front();
          if (got.x !== want.x || got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.is_pixel !== want.is_pixel ||
              got.line_end !== want.line_end) begin
            failures++;
            if (failures <= MaxReported)
              $display("mismatch: expected x=%0d rgb=%02h%02h%02h pix=%0b end=%0b, %s",
                       want.x, want.red, want.green, want.blue, want.is_pixel,
                       want.line_end,
                       $sformatf("got x=%0d rgb=%02h%02h%02h pix=%0b end=%0b",
                                 got.x, got.red, got.green, got.blue, got.is_pixel,
                                 got.line_end));
          end
        end
      end
    end
  end

  // Receiver stalls on a 16-bit pattern that is redrawn each time it runs out.
  always @(posedge clk_i) begin
    pop <= stall_bits[stall_pos];
    stall_pos <= stall_pos + 4'd1;
    if (stall_pos == 4'd15) begin
      case ($urandom_range(0, 4))
        0:       stall_bits <= 16'hFFFF;
        1:       stall_bits <= 16'h0001;
        2:       stall_bits <= 16'h0000;
        default: stall_bits <= 16'($urandom);
      endcase
    end
  end

  // Sends one word and returns at the edge where it is taken; bursts end in gaps.
  task automatic send_word(input logic [15:0] w);
    push <= 1'b1;
    word_i <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    words_sent++;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Waits until every predicted result has been popped and the block is settled.
  task automatic wait_idle;
    push <= 1'b0;
    @(posedge clk_i);
    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all three registers; unused data bits carry random values.
  task automatic configure(input bit raw, input bit green, input logic [14:0] width);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= rsld_pkg::RegRawMode;
    cfg_data_i <= {14'($urandom), raw};
    @(posedge clk_i);
    cfg_idx_i <= rsld_pkg::RegGreenSixBits;
    cfg_data_i <= {14'($urandom), green};
    @(posedge clk_i);
    cfg_idx_i <= rsld_pkg::RegLineWidth;
    cfg_data_i <= width;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_done++;
  endtask

  // Run-length line with runs, skips, an empty run, clipping and a saturated column.
  task automatic test_run_line;
    configure(1'b0, 1'b1, 15'd8);
    send_word(16'h1234);
    send_word(rsld_pkg::RunTag | 16'd3);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'hA5A5);
    send_word(16'h0002);
    send_word(rsld_pkg::RunTag);
    send_word(rsld_pkg::RunTag | 16'd4);
    send_word(16'h5A5A);
    send_word(16'h8001);
    send_word(16'h7FFE);
    send_word(16'h1234);
    send_word(16'hBFFF);
    send_word(16'h7FFF);
    send_word(rsld_pkg::RunTag | 16'd1);
    send_word(16'hFFFF);
    send_word(16'h0000);
    wait_idle();
  endtask

  // Raw line in 555 packing wrapping back to column zero.
  task automatic test_raw_line;
    configure(1'b1, 1'b0, 15'd3);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'h7C1F);
    send_word(16'h83E0);
    wait_idle();
  endtask

  // Zero line width in both modes; the raw state is kept across the mode change.
  task automatic test_zero_width;
    configure(1'b1, 1'b1, 15'd0);
    send_word(16'h4321);
    send_word(16'hFFFF);
    wait_idle();
    configure(1'b0, 1'b1, 15'd0);
    send_word(16'h0010);
    send_word(rsld_pkg::RunTag | 16'd1);
    send_word(16'hFFFF);
    send_word(16'h0000);
    wait_idle();
  endtask

  // One random run-length line, sometimes cut short before its end word.
  task automatic send_run_line;
    int          n_cmds;
    int          count;
    logic [15:0] w;
    send_word(16'($urandom));
    n_cmds = $urandom_range(1, 6);
    for (int i = 0; i < n_cmds; i++) begin
      if ($urandom_range(0, 4) < 3) begin
        count = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 300)
                                             : $urandom_range(0, 12);
        send_word(rsld_pkg::RunTag | 16'(count));
        for (int j = 0; j < count; j++) send_word(16'($urandom));
      end else begin
        w = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
        if (w[15:14] == 2'b11) w[15] = 1'b0;
        if (w == 16'h0000) w = 16'h0001;
        send_word(w);
      end
    end
    if ($urandom_range(0, 9) != 0) send_word(16'h0000);
  endtask

  // Random streams under a new register setting each time.
  task automatic test_random_streams;
    int          target;
    int          quota;
    bit          raw;
    logic [14:0] width;
    target = words_sent + 2000;
    while (words_sent < target) begin
      raw = ($urandom_range(0, 9) < 4);
      case ($urandom_range(0, 9))
        0:       width = 15'd0;
        1:       width = 15'd1;
        2:       width = 15'h7FFF;
        3:       width = 15'd2;
        default: width = 15'($urandom_range(3, 48));
      endcase
      configure(raw, 1'($urandom), width);
      quota = words_sent + $urandom_range(100, 250);
      while (words_sent < quota) begin
        if (raw) send_word(16'($urandom));
        else if ($urandom_range(0, 9) == 0) send_word(16'($urandom));
        else send_run_line();
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    word_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = rsld_pkg::RegRawMode;
    cfg_data_i = '0;
    cfg_q = '{raw_mode: 1'b0, green_six_bits: 1'b1, line_width: 15'd1};
    line_phase = rsld_pkg::PH_HEADER;
    run_left_q = '0;
    column_q = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_run_line();
    test_raw_line();
    test_zero_width();
    test_random_streams();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (pixel_queue.size() != 0) failures++;
    $display("covered %0d words under %0d register settings", words_sent, settings_done);
    $display("checked %0d pixels and %0d line-end markers, %0d failures",
             pixels_seen, markers_seen, failures);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
